FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Both expect signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Checked at every edge, reset included
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error(msg);

`endif

FILE: src/tmsa_pkg.sv
package tmsa_pkg;

  // Field widths
  localparam int COORD_W = 24;
  localparam int ENTRY_W = 21;
  localparam int ROW_W   = 63;
  localparam int D0_W    = 32;
  localparam int SUM_W   = 29;
  localparam int CNT_W   = 13;

  // Datapath widths
  localparam int OP_W    = 28;              // shared multiplier operand
  localparam int PROD_W  = 2 * OP_W;        // multiplier product
  localparam int ACC_W   = 47;              // sum of three rotation products
  localparam int RND_SH  = 18;              // Q2.18 fraction bits
  localparam int RND_W   = ACC_W - RND_SH;  // rounded rotated coordinate
  localparam int POS_W   = RND_W + 1;       // after translation
  localparam int SUB_W   = POS_W + 1;       // query minus position
  localparam int DIST_W  = 56;              // sum of three squares
  localparam int DEN_W   = DIST_W + 1;      // d0^2 + dist^2
  localparam int QUO_W   = 17;              // quotient never exceeds 1.0 in Q16
  localparam int DCNT_W  = $clog2(QUO_W + 1);
  localparam int FRAC_W  = 16;

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_D0_SQUARED = 3'd6;

  // Constants
  localparam logic [D0_W-1:0]  D0_RESET   = 32'h0001_0000;
  localparam logic [SUM_W-1:0] SUM_LIMIT  = 29'h1000_0000;
  localparam logic [QUO_W-1:0] ONE_Q16    = 17'h1_0000;
  localparam logic [ACC_W-1:0] ROUND_BIAS = 47'h2_0000;
  localparam int               COUNT_CAP  = 8191;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: src/tmsa_ifs.sv
// Pair input channel
interface tmsa_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tmsa_pkg::COORD_W-1:0] query_x;
  logic signed [tmsa_pkg::COORD_W-1:0] query_y;
  logic signed [tmsa_pkg::COORD_W-1:0] query_z;
  logic signed [tmsa_pkg::COORD_W-1:0] target_x;
  logic signed [tmsa_pkg::COORD_W-1:0] target_y;
  logic signed [tmsa_pkg::COORD_W-1:0] target_z;
  logic                                 last_pair;

  modport source (output valid, query_x, query_y, query_z,
                  target_x, target_y, target_z, last_pair, input ready);
  modport sink   (input valid, query_x, query_y, query_z,
                  target_x, target_y, target_z, last_pair, output ready);
endinterface

// Score result channel
interface tmsa_out_if;
  logic                         valid;
  logic                         ready;
  logic [tmsa_pkg::SUM_W-1:0]   score_sum;
  logic [tmsa_pkg::CNT_W-1:0]   pair_count;

  modport source (output valid, score_sum, pair_count, input ready);
  modport sink   (input valid, score_sum, pair_count, output ready);
endinterface

// Register write channel
interface tmsa_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tmsa_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [tmsa_pkg::ROW_W-1:0]       wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

FILE: src/tm_score_accumulator.sv
// Channel  Port    Dir  Payload
// -------  ------  ---  ----------------------------------------------------
// input    in_ch   in   query_x/y/z, target_x/y/z (s24), last_pair
// result   out_ch  out  score_sum (Q16, 29b), pair_count (13b)
// config   cfg_ch  in   reg_index (3b), wdata (63b); always ready
//
// A counted pair runs on the shared 28x28 multiplier (nine rotation
// products, three squares), then through set-up and the serial divider that
// yields one quotient bit per cycle, then a commit and a return to idle.
// A pair past the count limit goes straight to commit. rst_n is synchronous.
// A finished result waits in the output register while the next pair runs; a
// last pair stalls in its commit cycle only while that register is still full.
`include "assert_macros.svh"

module tm_score_accumulator #(
  parameter int MAX_PAIRS = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  tmsa_cfg_if.sink     cfg_ch,
  tmsa_in_if.sink      in_ch,
  tmsa_out_if.source   out_ch
);

  localparam int COORD_W = tmsa_pkg::COORD_W;
  localparam int ENTRY_W = tmsa_pkg::ENTRY_W;
  localparam int ROW_W   = tmsa_pkg::ROW_W;
  localparam int D0_W    = tmsa_pkg::D0_W;
  localparam int SUM_W   = tmsa_pkg::SUM_W;
  localparam int CNT_W   = tmsa_pkg::CNT_W;
  localparam int OP_W    = tmsa_pkg::OP_W;
  localparam int PROD_W  = tmsa_pkg::PROD_W;
  localparam int ACC_W   = tmsa_pkg::ACC_W;
  localparam int RND_SH  = tmsa_pkg::RND_SH;
  localparam int RND_W   = tmsa_pkg::RND_W;
  localparam int POS_W   = tmsa_pkg::POS_W;
  localparam int SUB_W   = tmsa_pkg::SUB_W;
  localparam int DIST_W  = tmsa_pkg::DIST_W;
  localparam int DEN_W   = tmsa_pkg::DEN_W;
  localparam int QUO_W   = tmsa_pkg::QUO_W;
  localparam int FRAC_W  = tmsa_pkg::FRAC_W;

  localparam int LIMIT_I = (MAX_PAIRS < tmsa_pkg::COUNT_CAP) ? MAX_PAIRS
                                                              : tmsa_pkg::COUNT_CAP;
  localparam logic [CNT_W-1:0] PAIR_LIMIT = CNT_W'(LIMIT_I);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DSET = 3'd2;
  localparam logic [2:0] S_DGO  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  // Micro-steps per axis
  localparam logic [2:0] MS_M0   = 3'd0;  // multiply x entry
  localparam logic [2:0] MS_M1   = 3'd1;  // multiply y entry, start sum
  localparam logic [2:0] MS_M2   = 3'd2;  // multiply z entry, accumulate
  localparam logic [2:0] MS_ACC  = 3'd3;  // accumulate last product
  localparam logic [2:0] MS_DIFF = 3'd4;  // round, translate, subtract
  localparam logic [2:0] MS_SQ   = 3'd5;  // square the difference
  localparam logic [2:0] MS_DIST = 3'd6;  // add square to distance

  localparam logic [1:0] AX_LAST = 2'd2;

  // Configuration registers
  logic [ROW_W-1:0]          rot_r [3];
  logic signed [COORD_W-1:0] shift_r [3];
  logic [D0_W-1:0]           d0_r;

  // Latched transaction
  logic signed [COORD_W-1:0] q_r [3];
  logic signed [COORD_W-1:0] t_r [3];
  logic                      last_r;
  logic                      add_r;

  // Sequencer and datapath
  logic [2:0]                state_r, state_nxt;
  logic [2:0]                ms_r, ms_nxt;
  logic [1:0]                ax_r, ax_nxt;
  logic signed [OP_W-1:0]    mul_a, mul_b;
  logic signed [PROD_W-1:0]  mul_prod;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [OP_W-1:0]    diff_r;
  logic [DIST_W-1:0]         dist_r;
  logic [DEN_W-1:0]          den_r;
  logic [QUO_W-1:0]          term_r;
  logic [ROW_W-1:0]          rot_sel;
  logic signed [RND_W-1:0]   rnd;
  logic signed [POS_W-1:0]   pos;
  logic signed [SUB_W-1:0]   diff_full;
  logic [D0_W-1:0]           d0_eff;
  logic [DEN_W-1:0]          div_num;
  logic                      div_start;
  logic [QUO_W-1:0]          div_quo;
  tmsa_pkg::div_stat_t       div_stat;

  // Running totals and result register
  logic [SUM_W-1:0]          running_r;
  logic [CNT_W-1:0]          pairs_r;
  logic [SUM_W:0]            sum_wide;
  logic [SUM_W-1:0]          sum_upd;
  logic [CNT_W-1:0]          cnt_upd;
  logic                      out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]          out_sum_r;
  logic [CNT_W-1:0]          out_cnt_r;
  logic                      in_acc;
  logic                      commit;
  logic                      load_out;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && (state_r == S_IDLE);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0]   <= '0;
      rot_r[1]   <= '0;
      rot_r[2]   <= '0;
      shift_r[0] <= '0;
      shift_r[1] <= '0;
      shift_r[2] <= '0;
      d0_r       <= tmsa_pkg::D0_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        tmsa_pkg::REG_ROT_ROW0:   rot_r[0]   <= cfg_ch.wdata;
        tmsa_pkg::REG_ROT_ROW1:   rot_r[1]   <= cfg_ch.wdata;
        tmsa_pkg::REG_ROT_ROW2:   rot_r[2]   <= cfg_ch.wdata;
        tmsa_pkg::REG_SHIFT_X:    shift_r[0] <= cfg_ch.wdata[COORD_W-1:0];
        tmsa_pkg::REG_SHIFT_Y:    shift_r[1] <= cfg_ch.wdata[COORD_W-1:0];
        tmsa_pkg::REG_SHIFT_Z:    shift_r[2] <= cfg_ch.wdata[COORD_W-1:0];
        tmsa_pkg::REG_D0_SQUARED: d0_r       <= cfg_ch.wdata[D0_W-1:0];
        default: ;
      endcase
    end
  end

  // Shared multiplier operand select
  always_comb begin
    rot_sel = rot_r[ax_r];
    case (ms_r)
      MS_M0: begin
        mul_a = OP_W'(signed'(rot_sel[0 +: ENTRY_W]));
        mul_b = OP_W'(t_r[0]);
      end
      MS_M1: begin
        mul_a = OP_W'(signed'(rot_sel[ENTRY_W +: ENTRY_W]));
        mul_b = OP_W'(t_r[1]);
      end
      MS_M2: begin
        mul_a = OP_W'(signed'(rot_sel[2*ENTRY_W +: ENTRY_W]));
        mul_b = OP_W'(t_r[2]);
      end
      default: begin
        mul_a = diff_r;
        mul_b = diff_r;
      end
    endcase
    mul_prod = mul_a * mul_b;
  end

  // Round half up to 1/256 A, translate, take the difference to the query
  always_comb begin
    rnd       = acc_r[ACC_W-1:RND_SH];
    pos       = POS_W'(rnd) + POS_W'(shift_r[ax_r]);
    diff_full = SUB_W'(q_r[ax_r]) - SUB_W'(pos);
  end

  // Divider operands; a zero scale counts as one
  always_comb begin
    d0_eff    = (d0_r == '0) ? D0_W'(1) : d0_r;
    div_num   = DEN_W'({d0_eff, {FRAC_W{1'b0}}}) + (den_r >> 1);
    div_start = (state_r == S_DGO);
  end

  tmsa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (den_r),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  // Totals after this pair, saturating sum
  always_comb begin
    sum_wide = {1'b0, running_r} + (SUM_W + 1)'(term_r);
    if (!add_r) begin
      sum_upd = running_r;
      cnt_upd = pairs_r;
    end else begin
      sum_upd = (sum_wide > (SUM_W + 1)'(tmsa_pkg::SUM_LIMIT)) ? tmsa_pkg::SUM_LIMIT
                                                               : sum_wide[SUM_W-1:0];
      cnt_upd = pairs_r + 1'b1;
    end
    commit   = (state_r == S_FIN) && (!last_r || !out_valid_r || out_ch.ready);
    load_out = commit && last_r;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    ms_nxt    = ms_r;
    ax_nxt    = ax_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ms_nxt    = MS_M0;
          ax_nxt    = '0;
          state_nxt = (pairs_r < PAIR_LIMIT) ? S_MUL : S_FIN;
        end
      end
      S_MUL: begin
        if (ms_r == MS_DIST) begin
          ms_nxt = MS_M0;
          if (ax_r == AX_LAST) begin
            state_nxt = S_DSET;
          end else begin
            ax_nxt = ax_r + 1'b1;
          end
        end else begin
          ms_nxt = ms_r + 1'b1;
        end
      end
      S_DSET: state_nxt = S_DGO;
      S_DGO:  state_nxt = S_DIV;
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ms_r        <= MS_M0;
      ax_r        <= '0;
      out_valid_r <= 1'b0;
      running_r   <= '0;
      pairs_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      ms_r        <= ms_nxt;
      ax_r        <= ax_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) begin
        running_r <= last_r ? '0 : sum_upd;
        pairs_r   <= last_r ? '0 : cnt_upd;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      q_r[0] <= in_ch.query_x;
      q_r[1] <= in_ch.query_y;
      q_r[2] <= in_ch.query_z;
      t_r[0] <= in_ch.target_x;
      t_r[1] <= in_ch.target_y;
      t_r[2] <= in_ch.target_z;
      last_r <= in_ch.last_pair;
      add_r  <= (pairs_r < PAIR_LIMIT);
      dist_r <= '0;
    end
    prod_r <= mul_prod;
    if (state_r == S_MUL) begin
      case (ms_r)
        MS_M1:   acc_r  <= ACC_W'(prod_r) + tmsa_pkg::ROUND_BIAS;
        MS_M2:   acc_r  <= acc_r + ACC_W'(prod_r);
        MS_ACC:  acc_r  <= acc_r + ACC_W'(prod_r);
        MS_DIFF: diff_r <= OP_W'(diff_full);
        MS_DIST: dist_r <= dist_r + DIST_W'(unsigned'(prod_r));
        default: ;
      endcase
    end
    if (state_r == S_DSET) begin
      den_r <= DEN_W'(d0_eff) + DEN_W'(dist_r);
    end
    if ((state_r == S_DIV) && div_stat.done) begin
      term_r <= (div_quo > tmsa_pkg::ONE_Q16) ? tmsa_pkg::ONE_Q16 : div_quo;
    end
    if (load_out) begin
      out_sum_r <= sum_upd;
      out_cnt_r <= cnt_upd;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.score_sum  = out_sum_r;
  assign out_ch.pair_count = out_cnt_r;

  `ASSERT_CLK(a_sum_capped, running_r <= tmsa_pkg::SUM_LIMIT, "running sum above limit")
  `ASSERT_CLK(a_pairs_capped, pairs_r <= PAIR_LIMIT, "pair count above limit")
  `ASSERT_CLK(a_out_drains, out_ch.valid && out_ch.ready && !load_out |=> !out_ch.valid, "result not retired")
  `ASSERT_CLK(a_div_only_in_div, div_stat.busy |-> (state_r == S_DIV), "divider busy outside divide phase")
  `ASSERT_RST(a_reset_quiet, !rst_n |=> !out_ch.valid && (state_r == S_IDLE), "not idle after reset")

endmodule

FILE: src/tmsa_div.sv
`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle.
// The caller guarantees num < den * 2^QUO_W, so the quotient fits QUO_W bits.
module tmsa_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tmsa_pkg::DEN_W-1:0]    num,
  input  logic [tmsa_pkg::DEN_W-1:0]    den,
  output logic [tmsa_pkg::QUO_W-1:0]    quo,
  output tmsa_pkg::div_stat_t           stat
);

  localparam int DEN_W  = tmsa_pkg::DEN_W;
  localparam int QUO_W  = tmsa_pkg::QUO_W;
  localparam int DCNT_W = tmsa_pkg::DCNT_W;

  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [QUO_W-1:0]  nb_r;
  logic [QUO_W-1:0]  quo_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  // Trial subtract with the next numerator bit brought down
  always_comb begin
    trial = {rem_r, nb_r[QUO_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(QUO_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DEN_W'(num >> QUO_W);
      nb_r  <= num[QUO_W-1:0];
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      nb_r  <= {nb_r[QUO_W-2:0], 1'b0};
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  `ASSERT_CLK(a_div_done_after_busy, done_r |-> $past(busy_r), "divider done without a run")
  `ASSERT_CLK(a_div_no_restart, start |-> !busy_r, "divider started while busy")
  `ASSERT_CLK(a_div_rem_below_den, busy_r |-> (rem_r < den_r), "divider remainder out of range")

endmodule

FILE: sim/tmsa_checker.sv
`timescale 1ns / 100ps

// Watches the three channels, predicts each score result and compares it
module tmsa_checker #(
  parameter int MAX_PAIRS = 4096
) (
  input  logic clk,
  input  logic rst_n,
  tmsa_cfg_if  cfg_ch,
  tmsa_in_if   in_ch,
  tmsa_out_if  out_ch,
  output int   mismatches,
  output int   scores_pending
);

  localparam int COORD_W = tmsa_pkg::COORD_W;
  localparam int ENTRY_W = tmsa_pkg::ENTRY_W;
  localparam int ROW_W   = tmsa_pkg::ROW_W;
  localparam int D0_W    = tmsa_pkg::D0_W;
  localparam int SUM_W   = tmsa_pkg::SUM_W;
  localparam int CNT_W   = tmsa_pkg::CNT_W;
  localparam int QUO_W   = tmsa_pkg::QUO_W;
  localparam int RND_SH  = tmsa_pkg::RND_SH;
  localparam int FRAC_W  = tmsa_pkg::FRAC_W;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [SUM_W-1:0] score_sum;
    logic [CNT_W-1:0] pair_count;
  } score_t;

  localparam int PAIR_LIMIT = (MAX_PAIRS < tmsa_pkg::COUNT_CAP) ? MAX_PAIRS
                                                                 : tmsa_pkg::COUNT_CAP;

  // Shadow of the register file and of the running totals
  logic [ROW_W-1:0] rot_q [3];
  coord_t           shift_q [3];
  logic [D0_W-1:0]  d0_sq;
  logic [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0] pairs_q;
  score_t           scores_due [$];

  // Signed Q2.18 entry for one column of a packed row
  function automatic longint row_entry(input logic [ROW_W-1:0] row, input int col);
    logic signed [ENTRY_W-1:0] e;
    e = row[col*ENTRY_W +: ENTRY_W];
    return e;
  endfunction

  // TM term d0^2 / (d0^2 + dist^2) in Q16 for one superposed pair
  function automatic logic [QUO_W-1:0] pair_term(input coord_t qx, qy, qz, tx, ty, tz);
    longint      qv [3];
    longint      tv [3];
    longint      p, pos, diff;
    logic [63:0] dist2, scale, den, quo;
    qv[0] = qx; qv[1] = qy; qv[2] = qz;
    tv[0] = tx; tv[1] = ty; tv[2] = tz;
    dist2 = 0;
    for (int i = 0; i < 3; i++) begin
      p = 0;
      for (int j = 0; j < 3; j++) begin
        p = p + row_entry(rot_q[i], j) * tv[j];
      end
      // round half up to 1/256 A, then translate
      pos   = ((p + (longint'(1) <<< (RND_SH - 1))) >>> RND_SH) + longint'(shift_q[i]);
      diff  = qv[i] - pos;
      dist2 = dist2 + diff * diff;
    end
    // a zero scale behaves as one
    scale = (d0_sq == '0) ? 64'd1 : 64'(d0_sq);
    den   = scale + dist2;
    quo   = ((scale << FRAC_W) + (den >> 1)) / den;
    return (quo > tmsa_pkg::ONE_Q16) ? tmsa_pkg::ONE_Q16 : quo[QUO_W-1:0];
  endfunction

  always @(posedge clk) begin : predict_and_compare
    logic [QUO_W-1:0] term;
    logic [SUM_W:0]   total;
    score_t           want;
    int               pushed, popped;
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        rot_q[i]   = '0;
        shift_q[i] = '0;
      end
      d0_sq   = tmsa_pkg::D0_RESET;
      sum_q   = '0;
      pairs_q = '0;
      scores_due.delete();
      scores_pending <= 0;
    end else begin
      pushed = 0;
      popped = 0;

      // register writes
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          tmsa_pkg::REG_ROT_ROW0:   rot_q[0]   = cfg_ch.wdata;
          tmsa_pkg::REG_ROT_ROW1:   rot_q[1]   = cfg_ch.wdata;
          tmsa_pkg::REG_ROT_ROW2:   rot_q[2]   = cfg_ch.wdata;
          tmsa_pkg::REG_SHIFT_X:    shift_q[0] = cfg_ch.wdata[COORD_W-1:0];
          tmsa_pkg::REG_SHIFT_Y:    shift_q[1] = cfg_ch.wdata[COORD_W-1:0];
          tmsa_pkg::REG_SHIFT_Z:    shift_q[2] = cfg_ch.wdata[COORD_W-1:0];
          tmsa_pkg::REG_D0_SQUARED: d0_sq      = cfg_ch.wdata[D0_W-1:0];
          default: ;
        endcase
      end

      // result transaction against the oldest expectation
      if (out_ch.valid && out_ch.ready) begin
        if (scores_due.size() == 0) begin
          $error("unexpected result: score_sum %0d pair_count %0d",
                 out_ch.score_sum, out_ch.pair_count);
          mismatches++;
        end else begin
          want   = scores_due.pop_front();
          popped = 1;
          if (out_ch.score_sum !== want.score_sum) begin
            $error("score_sum: expected %0d, actual %0d", want.score_sum, out_ch.score_sum);
            mismatches++;
          end
          if (out_ch.pair_count !== want.pair_count) begin
            $error("pair_count: expected %0d, actual %0d", want.pair_count,
                   out_ch.pair_count);
            mismatches++;
          end
        end
      end

      // pair transaction: accumulate, emit on the last mark
      if (in_ch.valid && in_ch.ready) begin
        if (pairs_q < PAIR_LIMIT) begin
          term    = pair_term(in_ch.query_x, in_ch.query_y, in_ch.query_z,
                              in_ch.target_x, in_ch.target_y, in_ch.target_z);
          total   = {1'b0, sum_q} + term;
          sum_q   = (total > tmsa_pkg::SUM_LIMIT) ? tmsa_pkg::SUM_LIMIT : total[SUM_W-1:0];
          pairs_q = pairs_q + 1'b1;
        end
        if (in_ch.last_pair) begin
          want.score_sum  = sum_q;
          want.pair_count = pairs_q;
          scores_due      = {scores_due, want};
          pushed  = 1;
          sum_q   = '0;
          pairs_q = '0;
        end
      end

      scores_pending <= scores_pending + pushed - popped;
    end
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int COORD_W   = tmsa_pkg::COORD_W;
  localparam int ENTRY_W   = tmsa_pkg::ENTRY_W;
  localparam int ROW_W     = tmsa_pkg::ROW_W;
  localparam int D0_W      = tmsa_pkg::D0_W;
  localparam int CFG_IDX_W = tmsa_pkg::CFG_IDX_W;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [ENTRY_W-1:0] entry_t;

  localparam int     MAX_PAIRS     = 4096;
  localparam int     LONG_CHAIN    = 100;
  localparam int     SETTLE_CYCLES = 60;
  localparam int     IDLE_LIMIT    = 2000;
  localparam int     RANDOM_PHASES = 8;
  localparam int     PHASE_PAIRS   = 110;
  localparam coord_t CMAX          = 24'sh7FFFFF;
  localparam coord_t CMIN          = 24'sh800000;
  localparam entry_t EMAX          = 21'sh0FFFFF;
  localparam entry_t EMIN          = 21'sh100000;
  localparam entry_t EONE          = 21'sh040000;  // 1.0 in Q2.18

  // Superposition flavours for the random phases
  typedef enum int {
    FIT_IDENTITY,
    FIT_SHIFTED,
    FIT_WIDE,
    FIT_NEAR_UNIT
  } fit_kind_t;

  logic clk = 1'b0;
  logic rst_n;
  int   mismatches;
  int   scores_pending;
  int   send_calm = 0;
  int   recv_calm = 0;
  int   idle_cycles = 0;

  coord_t cur_shift [3];

  always #5 clk = ~clk;

  tmsa_cfg_if cfg_ch ();
  tmsa_in_if  in_ch ();
  tmsa_out_if out_ch ();

  tm_score_accumulator #(.MAX_PAIRS(MAX_PAIRS)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tmsa_checker #(.MAX_PAIRS(MAX_PAIRS)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_ch         (cfg_ch),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatches     (mismatches),
    .scores_pending (scores_pending)
  );

  // Wait before the next transaction; occasional runs with no wait at all
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) calm = $urandom_range(5, 40);
    return $urandom_range(0, 15);
  endfunction

  function automatic logic [ROW_W-1:0] pack_row(input entry_t ex, ey, ez);
    return {ez, ey, ex};
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0: return coord_t'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: return CMAX;
          1: return CMIN;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return coord_t'(int'($urandom_range(0, 32767)) - 16384);
    endcase
  endfunction

  function automatic entry_t rand_entry_near_unit();
    return entry_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
  endfunction

  function automatic logic [D0_W-1:0] rand_scale();
    case ($urandom_range(0, 5))
      0: return tmsa_pkg::D0_RESET;
      1: return $urandom;
      2: return $urandom_range(0, 1);
      3: return 32'hFFFF_FFFF;
      default: return $urandom_range(1, 1 << 22);
    endcase
  endfunction

  // One pair transaction; valid stays up when the next one follows at once
  task automatic send_pair(input coord_t qx, qy, qz, tx, ty, tz,
                           input logic last, input bit paced);
    int n;
    n = paced ? draw_wait(send_calm) : 0;
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_ch.query_x   <= qx;
    in_ch.query_y   <= qy;
    in_ch.query_z   <= qz;
    in_ch.target_x  <= tx;
    in_ch.target_y  <= ty;
    in_ch.target_z  <= tz;
    in_ch.last_pair <= last;
    in_ch.valid     <= 1'b1;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  // Hold off until every score is back, then let any uncounted work finish
  task automatic settle_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (scores_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Full register file write, only once the block is idle
  task automatic reconfigure(input logic [ROW_W-1:0] r0, r1, r2,
                             input coord_t sx, sy, sz, input logic [D0_W-1:0] d0);
    logic [ROW_W-1:0]     value [7];
    logic [CFG_IDX_W-1:0] index [7];
    index[0] = tmsa_pkg::REG_ROT_ROW0;   value[0] = r0;
    index[1] = tmsa_pkg::REG_ROT_ROW1;   value[1] = r1;
    index[2] = tmsa_pkg::REG_ROT_ROW2;   value[2] = r2;
    index[3] = tmsa_pkg::REG_SHIFT_X;    value[3] = ROW_W'(sx);
    index[4] = tmsa_pkg::REG_SHIFT_Y;    value[4] = ROW_W'(sy);
    index[5] = tmsa_pkg::REG_SHIFT_Z;    value[5] = ROW_W'(sz);
    index[6] = tmsa_pkg::REG_D0_SQUARED; value[6] = ROW_W'(d0);
    settle_idle();
    for (int i = 0; i < 7; i++) begin
      cfg_ch.reg_index <= index[i];
      cfg_ch.wdata     <= value[i];
      cfg_ch.valid     <= 1'b1;
      do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    end
    cfg_ch.valid <= 1'b0;
    cur_shift[0] = sx;
    cur_shift[1] = sy;
    cur_shift[2] = sz;
  endtask

  // Result side back-pressure
  initial begin : result_sink
    int n;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = draw_wait(recv_calm);
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    fit_kind_t        kind;
    logic [ROW_W-1:0] r0, r1, r2;
    coord_t           sx, sy, sz;
    coord_t           q [3];
    coord_t           t [3];
    int               sent, chain_len;

    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.query_x    = '0;
    in_ch.query_y    = '0;
    in_ch.query_z    = '0;
    in_ch.target_x   = '0;
    in_ch.target_y   = '0;
    in_ch.target_z   = '0;
    in_ch.last_pair  = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = tmsa_pkg::REG_ROT_ROW0;
    cfg_ch.wdata     = '0;
    for (int i = 0; i < 3; i++) cur_shift[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: zero rotation and shift, so every target lands on the origin
    send_pair('0, '0, '0, rand_coord(), rand_coord(), rand_coord(), 1'b1, 1'b1);
    send_pair(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 1'b0, 1'b1);
    send_pair(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1'b0, 1'b1);
    send_pair(24'sd256, '0, '0, '0, '0, '0, 1'b1, 1'b1);

    // identity fit: coincident extremes, opposite extremes, and one pair 1 A apart
    reconfigure(pack_row(EONE, '0, '0), pack_row('0, EONE, '0), pack_row('0, '0, EONE),
                '0, '0, '0, tmsa_pkg::D0_RESET);
    send_pair(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1'b0, 1'b1);
    send_pair(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1'b0, 1'b1);
    send_pair(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1'b0, 1'b1);
    send_pair(24'sd256, '0, '0, '0, '0, '0, 1'b1, 1'b1);

    // extreme matrix entries and shifts, zero scale
    reconfigure(pack_row(EMAX, EMIN, EMAX), pack_row(EMIN, EMAX, EMIN), '1,
                CMAX, CMIN, CMAX, '0);
    send_pair(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1'b0, 1'b1);
    send_pair(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1'b0, 1'b1);
    send_pair('0, '0, '0, CMAX, CMIN, CMAX, 1'b0, 1'b1);
    send_pair(CMAX, CMIN, '0, '0, '0, '0, 1'b1, 1'b1);

    // most negative entries and shift, largest scale
    reconfigure(pack_row(EMIN, EMIN, EMIN), pack_row(EMIN, EMIN, EMIN),
                pack_row(EMIN, EMIN, EMIN), CMIN, CMIN, CMIN, 32'hFFFF_FFFF);
    send_pair(CMIN, CMIN, CMIN, '0, '0, '0, 1'b0, 1'b1);
    send_pair(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1'b0, 1'b1);
    send_pair('0, '0, '0, CMIN, CMIN, CMIN, 1'b1, 1'b1);

    // one long chain sent back to back, every term a full 1.0
    reconfigure(pack_row(EONE, '0, '0), pack_row('0, EONE, '0), pack_row('0, '0, EONE),
                '0, '0, '0, tmsa_pkg::D0_RESET);
    for (int k = 0; k < LONG_CHAIN; k++) begin
      for (int i = 0; i < 3; i++) q[i] = rand_coord();
      send_pair(q[0], q[1], q[2], q[0], q[1], q[2], k == LONG_CHAIN - 1, 1'b0);
    end

    // random phases, each under its own superposition
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      kind = fit_kind_t'((ph < 4) ? ph : $urandom_range(0, 3));
      case (kind)
        FIT_IDENTITY, FIT_SHIFTED: begin
          r0 = pack_row(EONE, '0, '0);
          r1 = pack_row('0, EONE, '0);
          r2 = pack_row('0, '0, EONE);
        end
        FIT_WIDE: begin
          r0 = ROW_W'({$urandom, $urandom});
          r1 = ROW_W'({$urandom, $urandom});
          r2 = ROW_W'({$urandom, $urandom});
        end
        default: begin
          r0 = pack_row(rand_entry_near_unit(), rand_entry_near_unit(), rand_entry_near_unit());
          r1 = pack_row(rand_entry_near_unit(), rand_entry_near_unit(), rand_entry_near_unit());
          r2 = pack_row(rand_entry_near_unit(), rand_entry_near_unit(), rand_entry_near_unit());
        end
      endcase
      if (kind == FIT_IDENTITY) begin
        sx = '0; sy = '0; sz = '0;
      end else begin
        sx = rand_coord(); sy = rand_coord(); sz = rand_coord();
      end
      reconfigure(r0, r1, r2, sx, sy, sz, rand_scale());

      sent = 0;
      while (sent < PHASE_PAIRS) begin
        chain_len = $urandom_range(1, 30);
        for (int k = 0; k < chain_len; k++) begin
          for (int i = 0; i < 3; i++) begin
            q[i] = rand_coord();
            // mostly near the query point under the identity fits, anywhere otherwise
            if ((kind == FIT_IDENTITY || kind == FIT_SHIFTED) && $urandom_range(0, 4) != 0)
              t[i] = q[i] - cur_shift[i] + coord_t'(int'($urandom_range(0, 1023)) - 512);
            else
              t[i] = rand_coord();
          end
          send_pair(q[0], q[1], q[2], t[0], t[1], t[2], k == chain_len - 1, 1'b1);
        end
        sent += chain_len;
      end
    end

    settle_idle();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
